### rtl/core/spi_flash_op_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// SPI flash op sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef SPI_FLASH_OP_SEQUENCER_UNIT_MACROS_SVH
`define SPI_FLASH_OP_SEQUENCER_UNIT_MACROS_SVH

// Clocked check that is held off while reset is high.
`define SFOS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also applies while reset is high.
`define SFOS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sfos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash op sequencer package
// Types, codes and sizing constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package sfos_pkg;

   localparam int PAGE_BYTES = 256;
   localparam int ADDR_BITS  = 24;

   localparam int WRAP_BITS = (ADDR_BITS < 24) ? ADDR_BITS : 24;
   localparam logic [23:0] WRAP_MASK  = 24'((64'd1 << WRAP_BITS) - 64'd1);
   localparam logic [23:0] PAGE_ADDR  = 24'(PAGE_BYTES);
   localparam logic [24:0] PAGE_COUNT = 25'(PAGE_BYTES);
   localparam logic [31:0] PAGE_BUF   = 32'(PAGE_BYTES);

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEFAULT_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROGRAM_TIMEOUT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ERASE_TIMEOUT   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_DUMMY      = 2'd3;

   localparam logic [31:0] RST_DEFAULT_TIMEOUT = 32'd5000;
   localparam logic [31:0] RST_PROGRAM_TIMEOUT = 32'd5;
   localparam logic [31:0] RST_ERASE_TIMEOUT   = 32'd3000;
   localparam logic [3:0]  RST_READ_DUMMY      = 4'd10;

   localparam logic [3:0] CMD_READ     = 4'd0;
   localparam logic [3:0] CMD_ERASE    = 4'd1;
   localparam logic [3:0] CMD_WRITE    = 4'd2;
   localparam logic [3:0] CMD_CMD_DONE = 4'd3;
   localparam logic [3:0] CMD_TX_DONE  = 4'd4;
   localparam logic [3:0] CMD_RX_DONE  = 4'd5;
   localparam logic [3:0] CMD_MATCH    = 4'd6;
   localparam logic [3:0] CMD_TICK     = 4'd7;
   localparam logic [3:0] CMD_REJECTED = 4'd8;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_WREN     = 3'd1;
   localparam logic [2:0] ACT_POLL_WEL = 3'd2;
   localparam logic [2:0] ACT_POLL_RDY = 3'd3;
   localparam logic [2:0] ACT_ERASE    = 3'd4;
   localparam logic [2:0] ACT_PROGRAM  = 3'd5;
   localparam logic [2:0] ACT_READ     = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [3:0] PHASE_IDLE_CODE = 4'd0;
   localparam logic [3:0] PHASE_READ_CODE = 4'd1;

   typedef enum logic [15:0] {
      PH_IDLE    = 16'h0001,
      PH_READ    = 16'h0002,
      PH_ER_WREN = 16'h0004,
      PH_ER_WEL  = 16'h0008,
      PH_ER_SENT = 16'h0010,
      PH_ER_POLL = 16'h0020,
      PH_PG_WREN = 16'h0040,
      PH_PG_WEL  = 16'h0080,
      PH_PG_PEND = 16'h0100,
      PH_PG_DATA = 16'h0200,
      PH_PG_POLL = 16'h0400,
      PH_LS_WREN = 16'h0800,
      PH_LS_WEL  = 16'h1000,
      PH_LS_PEND = 16'h2000,
      PH_LS_DATA = 16'h4000,
      PH_LS_POLL = 16'h8000
   } phase_type;

   typedef struct packed {
      logic [31:0] default_timeout;
      logic [31:0] program_timeout;
      logic [31:0] erase_timeout;
      logic [3:0]  read_dummy;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [23:0] cur_addr;
      logic [24:0] bytes_left;
      logic [31:0] buf_ptr;
      logic [31:0] elapsed;
      logic [31:0] limit;
      logic [1:0]  status;
   } state_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [23:0] flash_address;
      logic [24:0] byte_count;
      logic [31:0] buffer_address;
      logic        from_this_controller;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [23:0] action_address;
      logic [24:0] action_count;
      logic [31:0] action_buffer;
      logic [3:0]  action_dummy;
      logic [3:0]  phase;
      logic [1:0]  op_status;
      logic        request_refused;
   } rsp_type;

endpackage

### rtl/core/sfos_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash op sequencer step
// Next-state and action logic for one request or controller event.
// ----------------------------------------------------------------------------
module sfos_step (
   input  sfos_pkg::cfg_type   cfg,
   input  sfos_pkg::state_type state,
   input  sfos_pkg::req_type   req,
   output sfos_pkg::state_type state_next,
   output sfos_pkg::rsp_type   result
);
   import sfos_pkg::*;

   state_type   nxt;
   rsp_type     res;
   logic [23:0] next_page_addr;
   logic [24:0] page_left;
   logic [31:0] tick_elapsed;

   function automatic logic [3:0] phase_code(phase_type p);
      logic [3:0] code;
      case (p)
         PH_IDLE:    code = 4'd0;
         PH_READ:    code = 4'd1;
         PH_ER_WREN: code = 4'd2;
         PH_ER_WEL:  code = 4'd3;
         PH_ER_SENT: code = 4'd4;
         PH_ER_POLL: code = 4'd5;
         PH_PG_WREN: code = 4'd6;
         PH_PG_WEL:  code = 4'd7;
         PH_PG_PEND: code = 4'd8;
         PH_PG_DATA: code = 4'd9;
         PH_PG_POLL: code = 4'd10;
         PH_LS_WREN: code = 4'd11;
         PH_LS_WEL:  code = 4'd12;
         PH_LS_PEND: code = 4'd13;
         PH_LS_DATA: code = 4'd14;
         PH_LS_POLL: code = 4'd15;
         default:    code = 4'd0;
      endcase
      return code;
   endfunction

   assign next_page_addr = 24'({1'b0, state.cur_addr} + {1'b0, PAGE_ADDR}) & WRAP_MASK;
   assign page_left      = (state.bytes_left >= PAGE_COUNT) ?
                           (state.bytes_left - PAGE_COUNT) : 25'd0;
   assign tick_elapsed   = (&state.elapsed) ? state.elapsed : (state.elapsed + 32'd1);

   always_comb begin
      nxt = state;
      res = '0;
      case (req.cmd)
         CMD_READ, CMD_ERASE, CMD_WRITE: begin
            if (state.phase != PH_IDLE) begin
               res.request_refused = 1'b1;
            end else if (req.cmd == CMD_ERASE) begin
               nxt.cur_addr = req.flash_address & WRAP_MASK;
               nxt.phase    = PH_ER_WREN;
               nxt.status   = ST_BUSY;
               nxt.elapsed  = '0;
               nxt.limit    = cfg.default_timeout;
               res.action   = ACT_WREN;
            end else if (req.byte_count == '0) begin
               nxt.status = ST_OK;
            end else if (req.cmd == CMD_READ) begin
               nxt.cur_addr       = req.flash_address & WRAP_MASK;
               nxt.buf_ptr        = req.buffer_address;
               nxt.bytes_left     = req.byte_count;
               nxt.phase          = PH_READ;
               nxt.status         = ST_BUSY;
               nxt.elapsed        = '0;
               nxt.limit          = cfg.default_timeout;
               res.action         = ACT_READ;
               res.action_address = req.flash_address & WRAP_MASK;
               res.action_count   = req.byte_count;
               res.action_buffer  = req.buffer_address;
               res.action_dummy   = cfg.read_dummy;
            end else begin
               nxt.cur_addr   = req.flash_address & WRAP_MASK;
               nxt.buf_ptr    = req.buffer_address;
               nxt.bytes_left = req.byte_count;
               nxt.phase      = (req.byte_count >= PAGE_COUNT) ? PH_PG_WREN : PH_LS_WREN;
               nxt.status     = ST_BUSY;
               nxt.elapsed    = '0;
               nxt.limit      = cfg.default_timeout;
               res.action     = ACT_WREN;
            end
         end
         CMD_TICK: begin
            nxt.elapsed = tick_elapsed;
            if (state.phase inside {PH_PG_PEND, PH_LS_PEND}) begin
               res.action         = ACT_PROGRAM;
               res.action_address = state.cur_addr;
               res.action_count   = (state.phase == PH_PG_PEND) ? PAGE_COUNT : state.bytes_left;
               res.action_buffer  = state.buf_ptr;
               nxt.phase          = (state.phase == PH_PG_PEND) ? PH_PG_DATA : PH_LS_DATA;
               nxt.status         = ST_BUSY;
               nxt.elapsed        = '0;
               nxt.limit          = cfg.program_timeout;
            end
            if (nxt.phase != PH_IDLE && nxt.elapsed >= nxt.limit) begin
               nxt.phase  = PH_IDLE;
               nxt.status = ST_ERROR;
            end
         end
         CMD_CMD_DONE: begin
            if (req.from_this_controller) begin
               if (state.phase inside {PH_ER_WREN, PH_PG_WREN, PH_LS_WREN}) begin
                  case (state.phase)
                     PH_ER_WREN: nxt.phase = PH_ER_WEL;
                     PH_PG_WREN: nxt.phase = PH_PG_WEL;
                     default:    nxt.phase = PH_LS_WEL;
                  endcase
                  nxt.elapsed = '0;
                  nxt.limit   = cfg.default_timeout;
                  res.action  = ACT_POLL_WEL;
               end else if (state.phase == PH_ER_SENT) begin
                  nxt.phase   = PH_ER_POLL;
                  nxt.status  = ST_BUSY;
                  nxt.elapsed = '0;
                  nxt.limit   = cfg.default_timeout;
                  res.action  = ACT_POLL_RDY;
               end
            end
         end
         CMD_TX_DONE: begin
            if (req.from_this_controller && (state.phase inside {PH_PG_DATA, PH_LS_DATA})) begin
               nxt.phase   = (state.phase == PH_PG_DATA) ? PH_PG_POLL : PH_LS_POLL;
               nxt.status  = ST_BUSY;
               nxt.elapsed = '0;
               nxt.limit   = cfg.default_timeout;
               res.action  = ACT_POLL_RDY;
            end
         end
         CMD_RX_DONE: begin
            if (req.from_this_controller && state.phase == PH_READ) begin
               nxt.phase  = PH_IDLE;
               nxt.status = ST_OK;
            end
         end
         CMD_MATCH: begin
            if (req.from_this_controller) begin
               if (state.phase == PH_ER_WEL) begin
                  nxt.phase          = PH_ER_SENT;
                  nxt.status         = ST_BUSY;
                  nxt.elapsed        = '0;
                  nxt.limit          = cfg.erase_timeout;
                  res.action         = ACT_ERASE;
                  res.action_address = state.cur_addr;
               end else if (state.phase inside {PH_ER_POLL, PH_LS_POLL}) begin
                  nxt.phase  = PH_IDLE;
                  nxt.status = ST_OK;
               end else if (state.phase == PH_PG_WEL) begin
                  nxt.phase = PH_PG_PEND;
               end else if (state.phase == PH_LS_WEL) begin
                  nxt.phase = PH_LS_PEND;
               end else if (state.phase == PH_PG_POLL) begin
                  nxt.cur_addr   = next_page_addr;
                  nxt.buf_ptr    = state.buf_ptr + PAGE_BUF;
                  nxt.bytes_left = page_left;
                  if (page_left == '0) begin
                     nxt.phase  = PH_IDLE;
                     nxt.status = ST_OK;
                  end else begin
                     nxt.phase   = (page_left >= PAGE_COUNT) ? PH_PG_WREN : PH_LS_WREN;
                     nxt.elapsed = '0;
                     nxt.limit   = cfg.default_timeout;
                     res.action  = ACT_WREN;
                  end
               end
            end
         end
         CMD_REJECTED: begin
            if (req.from_this_controller && state.phase != PH_IDLE) begin
               nxt.phase  = PH_IDLE;
               nxt.status = ST_ERROR;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result           = res;
      result.phase     = phase_code(nxt.phase);
      result.op_status = nxt.status;
   end

   assign state_next = nxt;

endmodule

### rtl/core/spi_flash_op_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash op sequencer unit
// Turns flash requests and controller events into controller actions.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake          Word
//   req_      in          valid / stall      one request or controller event
//   rsp_      out         valid / stall      one action with phase and status
//   csr_      in          valid / ready      register index and write data
//
// Each accepted word yields one registered response word, one word per cycle
// sustained while rsp_stall is low; the single step block sets that figure.
// A response register plus one skid register let a word be taken while the
// previous response is still stalled; req_stall rises only when both are full.
// Synchronous reset idles the sequencer, loads CSR defaults, clears valid bits.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module spi_flash_op_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [3:0]                          req_cmd,
   input  logic [23:0]                         req_flash_address,
   input  logic [24:0]                         req_byte_count,
   input  logic [31:0]                         req_buffer_address,
   input  logic                                req_from_this_controller,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_action,
   output logic [23:0]                         rsp_action_address,
   output logic [24:0]                         rsp_action_count,
   output logic [31:0]                         rsp_action_buffer,
   output logic [3:0]                          rsp_action_dummy,
   output logic [3:0]                          rsp_phase,
   output logic [1:0]                          rsp_op_status,
   output logic                                rsp_request_refused,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfos_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_data
);
   import sfos_pkg::*;

   `include "spi_flash_op_sequencer_unit_macros.svh"

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_next;
   req_type   req;
   rsp_type   step_rsp;
   rsp_type   out_ff, out_in;
   rsp_type   skid_ff, skid_in;
   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   logic      req_acc;
   logic      out_take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   assign req = '{cmd: req_cmd, flash_address: req_flash_address,
                  byte_count: req_byte_count, buffer_address: req_buffer_address,
                  from_this_controller: req_from_this_controller};

   sfos_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .req        (req),
      .state_next (state_next),
      .result     (step_rsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEFAULT_TIMEOUT: cfg_in.default_timeout = csr_data;
            CSR_PROGRAM_TIMEOUT: cfg_in.program_timeout = csr_data;
            CSR_ERASE_TIMEOUT:   cfg_in.erase_timeout   = csr_data;
            CSR_READ_DUMMY:      cfg_in.read_dummy      = csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = step_rsp;
            skid_valid_in = req_acc;
         end else begin
            out_in       = step_rsp;
            out_valid_in = req_acc;
         end
      end else if (req_acc) begin
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_timeout <= RST_DEFAULT_TIMEOUT;
         cfg_ff.program_timeout <= RST_PROGRAM_TIMEOUT;
         cfg_ff.erase_timeout   <= RST_ERASE_TIMEOUT;
         cfg_ff.read_dummy      <= RST_READ_DUMMY;
         state_ff.phase         <= PH_IDLE;
         state_ff.cur_addr      <= '0;
         state_ff.bytes_left    <= '0;
         state_ff.buf_ptr       <= '0;
         state_ff.elapsed       <= '0;
         state_ff.limit         <= RST_DEFAULT_TIMEOUT;
         state_ff.status        <= ST_OK;
         out_valid_ff           <= 1'b0;
         skid_valid_ff          <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_acc) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_action          = out_ff.action;
   assign rsp_action_address  = out_ff.action_address;
   assign rsp_action_count    = out_ff.action_count;
   assign rsp_action_buffer   = out_ff.action_buffer;
   assign rsp_action_dummy    = out_ff.action_dummy;
   assign rsp_phase           = out_ff.phase;
   assign rsp_op_status       = out_ff.op_status;
   assign rsp_request_refused = out_ff.request_refused;

   `SFOS_ASSERT(a_skid_behind_out, clock, reset,
      skid_valid_ff |-> out_valid_ff,
      "skid word without response word")
   `SFOS_ASSERT(a_stalled_goes_skid, clock, reset,
      (req_acc && out_valid_ff && rsp_stall) |=> skid_valid_ff,
      "word lost behind stalled response")
   `SFOS_ASSERT(a_refused_busy, clock, reset,
      (rsp_valid && rsp_request_refused) |-> (rsp_phase != PHASE_IDLE_CODE),
      "request refused while idle")
   `SFOS_ASSERT(a_error_idle, clock, reset,
      (rsp_valid && rsp_op_status == ST_ERROR) |-> (rsp_phase == PHASE_IDLE_CODE),
      "error status outside idle")
   `SFOS_ASSERT(a_read_phase, clock, reset,
      (rsp_valid && rsp_action == ACT_READ) |-> (rsp_phase == PHASE_READ_CODE),
      "read issued outside read phase")

endmodule
